[hdl/emht_pkg.sv]
package emht_pkg;

  localparam int TRACK_SLOTS_DEF = 16;
  localparam int EMBED_LEN_DEF   = 512;
  localparam int RUN_LENGTH_DEF  = 3;

  localparam int SLOT_BITS = 4;
  localparam int GEN_W     = 32;
  localparam int ELEM_W    = 16;
  localparam int THR_W     = 17;
  localparam int SCORE_W   = 17;
  localparam int PROD_W    = 32;

  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_OBSERVE = 2'd1,
    CMD_EXPIRE  = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  localparam logic KIND_ASSIGN  = 1'b0;
  localparam logic KIND_OBSERVE = 1'b1;

  typedef struct packed {
    cmd_t                        cmd;
    logic [SLOT_BITS-1:0]        slot;
    logic                        slot_ok;
    logic                        match;
    logic                        last;
    logic signed [THR_W-1:0]     thr;
    logic                        known;
  } item_ctl_t;

endpackage

[hdl/emht_ref_mem.sv]
module emht_ref_mem #(
  parameter int TRACK_SLOTS = emht_pkg::TRACK_SLOTS_DEF,
  parameter int EMBED_LEN   = emht_pkg::EMBED_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic                                 re,
  input  logic [ADDR_W-1:0]                    addr,
  input  logic signed [emht_pkg::ELEM_W-1:0]   wdata,
  output logic signed [emht_pkg::ELEM_W-1:0]   rdata
);

  localparam int SLOT_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int IDX_W  = (EMBED_LEN > 1) ? $clog2(EMBED_LEN) : 1;
  localparam int ADDR_W = SLOT_W + IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic signed [emht_pkg::ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/emht_mac.sv]
module emht_mac #(
  parameter int EMBED_LEN = emht_pkg::EMBED_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  emht_pkg::item_ctl_t                  in_ctl,
  input  logic                                 in_counted,
  input  logic signed [emht_pkg::ELEM_W-1:0]   in_elem,
  input  logic signed [emht_pkg::ELEM_W-1:0]   ref_elem,
  output logic                                 out_valid,
  output emht_pkg::item_ctl_t                  out_ctl,
  output logic signed [ACC_W-1:0]              out_sum
);

  localparam int ACC_W = emht_pkg::PROD_W + 1 + ((EMBED_LEN > 1) ? $clog2(EMBED_LEN) : 1);

  logic                                 prod_valid;
  emht_pkg::item_ctl_t                  prod_ctl;
  logic signed [emht_pkg::PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]              acc;
  logic signed [ACC_W-1:0]              acc_sum;
  logic                                 use_prod;
  logic                                 stream_end;

  assign use_prod   = in_counted && in_ctl.slot_ok && (in_ctl.cmd == emht_pkg::CMD_OBSERVE);
  assign acc_sum    = acc + ACC_W'(prod);
  assign stream_end = prod_ctl.last || (prod_ctl.cmd == emht_pkg::CMD_EXPIRE) ||
                      (prod_ctl.cmd == emht_pkg::CMD_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
      acc        <= '0;
    end else if (en) begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
      if (prod_valid) begin
        acc <= stream_end ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_ctl <= in_ctl;
      prod     <= use_prod ? emht_pkg::PROD_W'(in_elem * ref_elem) : '0;
      out_ctl  <= prod_ctl;
      out_sum  <= acc_sum;
    end
  end

endmodule

[hdl/emht_slot_table.sv]
module emht_slot_table #(
  parameter int TRACK_SLOTS = emht_pkg::TRACK_SLOTS_DEF,
  parameter int RUN_LENGTH  = emht_pkg::RUN_LENGTH_DEF,
  parameter int ACC_W       = 43
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  emht_pkg::item_ctl_t                   in_ctl,
  input  logic signed [ACC_W-1:0]               in_sum,
  output logic                                  res_valid,
  output logic                                  res_accepted,
  output logic signed [emht_pkg::SCORE_W-1:0]   res_score,
  output logic                                  res_visible,
  output logic                                  res_kind
);

  localparam int SLOT_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int RUN_W  = $clog2(RUN_LENGTH + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(RUN_LENGTH);
  localparam logic signed [ACC_W-1:0] POS_ONE = ACC_W'(emht_pkg::ONE_Q30);
  localparam logic signed [ACC_W-1:0] NEG_ONE = -POS_ONE;

  logic                                 occupied   [TRACK_SLOTS];
  logic                                 vis        [TRACK_SLOTS];
  logic [RUN_W-1:0]                     high_run   [TRACK_SLOTS];
  logic [RUN_W-1:0]                     low_run    [TRACK_SLOTS];
  logic signed [emht_pkg::THR_W-1:0]    slot_thr   [TRACK_SLOTS];

  logic [SLOT_W-1:0]          idx;
  logic signed [ACC_W-1:0]    clamp_wide;
  logic signed [31:0]         clamped;
  logic signed [31:0]         thr_q30;
  logic                       ge;
  logic                       cur_vis;
  logic                       load_ok;
  logic                       obs_ok;
  logic [RUN_W-1:0]           high_next;
  logic [RUN_W-1:0]           low_next;
  logic                       vis_obs;
  logic                       is_load;
  logic                       is_obs;

  always_comb begin
    idx = in_ctl.slot_ok ? SLOT_W'(in_ctl.slot) : '0;
    if (in_sum > POS_ONE) begin
      clamp_wide = POS_ONE;
    end else if (in_sum < NEG_ONE) begin
      clamp_wide = NEG_ONE;
    end else begin
      clamp_wide = in_sum;
    end
    clamped = clamp_wide[31:0];
    thr_q30 = {slot_thr[idx], 15'b0};
    ge      = clamped >= thr_q30;
    cur_vis = vis[idx];
    is_load = in_ctl.cmd == emht_pkg::CMD_LOAD;
    is_obs  = in_ctl.cmd == emht_pkg::CMD_OBSERVE;
    load_ok = in_ctl.slot_ok && in_ctl.match;
    obs_ok  = in_ctl.slot_ok && occupied[idx];
    if (ge) begin
      high_next = (high_run[idx] < RUN_MAX) ? high_run[idx] + 1'b1 : high_run[idx];
      low_next  = '0;
      vis_obs   = (high_next == RUN_MAX) ? 1'b1 : cur_vis;
    end else begin
      high_next = '0;
      low_next  = (low_run[idx] < RUN_MAX) ? low_run[idx] + 1'b1 : low_run[idx];
      vis_obs   = (low_next == RUN_MAX) ? 1'b0 : cur_vis;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACK_SLOTS; i++) begin
        occupied[i] <= 1'b0;
        vis[i]      <= 1'b0;
        high_run[i] <= '0;
        low_run[i]  <= '0;
      end
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= in_valid && in_ctl.last && (is_load || is_obs);
      if (in_valid) begin
        case (in_ctl.cmd)
          emht_pkg::CMD_LOAD: begin
            if (in_ctl.last && load_ok) begin
              occupied[idx] <= 1'b1;
              vis[idx]      <= in_ctl.known;
              high_run[idx] <= '0;
              low_run[idx]  <= '0;
            end
          end
          emht_pkg::CMD_OBSERVE: begin
            if (in_ctl.last && obs_ok) begin
              vis[idx]      <= vis_obs;
              high_run[idx] <= high_next;
              low_run[idx]  <= low_next;
            end
          end
          emht_pkg::CMD_EXPIRE: begin
            if (load_ok) begin
              occupied[idx] <= 1'b0;
              vis[idx]      <= 1'b0;
              high_run[idx] <= '0;
              low_run[idx]  <= '0;
            end
          end
          emht_pkg::CMD_CLEAR: begin
            for (int i = 0; i < TRACK_SLOTS; i++) begin
              occupied[i] <= 1'b0;
              vis[i]      <= 1'b0;
              high_run[i] <= '0;
              low_run[i]  <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid && is_load && in_ctl.last && load_ok) begin
      slot_thr[idx] <= in_ctl.thr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (is_load) begin
        res_accepted <= load_ok;
        res_score    <= '0;
        res_visible  <= in_ctl.slot_ok && (load_ok ? in_ctl.known : cur_vis);
        res_kind     <= emht_pkg::KIND_ASSIGN;
      end else begin
        res_accepted <= obs_ok;
        res_score    <= obs_ok ? clamped[31:15] : '0;
        res_visible  <= in_ctl.slot_ok && (obs_ok ? vis_obs : cur_vis);
        res_kind     <= emht_pkg::KIND_OBSERVE;
      end
    end
  end

endmodule

[hdl/embedding_match_hysteresis_table.sv]
// Track-slot table that scores observed embeddings against stored references.
// Input stream (s_*): one embedding element per transfer; s_tuser selects
// load reference, observe, expire slot or clear all, s_tlast ends a stream.
// A load or observe stream gives one result transfer (m_*) after its last
// element; expire and clear give none. cfg_we/cfg_wdata set the generation
// that loads and expiries must carry; write it only while the block is idle.
// Throughput: one element per cycle while no result waits on m_tready, set by
// the single-port reference memory and the multiply-accumulate, both of which
// take an element every cycle. A result is on m_tdata once its last element
// has passed memory read, multiply, accumulate, and scoring and slot update.
// Reset clears the slot flags, run counters, visibility, stream counter and
// accumulator and sets the generation to 0; the reference memory and the
// thresholds keep their contents and need no clearing pass.
// When a result waits with m_tready low, the whole pipeline holds and
// s_tready drops until the result transfer completes.
module embedding_match_hysteresis_table #(
  parameter int TRACK_SLOTS = emht_pkg::TRACK_SLOTS_DEF,
  parameter int EMBED_LEN   = emht_pkg::EMBED_LEN_DEF,
  parameter int RUN_LENGTH  = emht_pkg::RUN_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot[3:0], generation[35:4], element_value[51:36], threshold[68:52],
  // initially_known[69], zero[71:70]
  input  logic [71:0] s_tdata,
  // command[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // accepted[0], score[17:1], visible_known[18], zero[23:19]
  output logic [23:0] m_tdata,
  // result_kind[0]
  output logic        m_tuser
);

  localparam int SLOT_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int IDX_W  = (EMBED_LEN > 1) ? $clog2(EMBED_LEN) : 1;
  localparam int CNT_W  = $clog2(EMBED_LEN + 1);
  localparam int ADDR_W = SLOT_W + IDX_W;
  localparam int ACC_W  = emht_pkg::PROD_W + 1 + IDX_W;

  logic [emht_pkg::GEN_W-1:0]          current_generation;
  logic [CNT_W-1:0]                    elem_cnt;
  logic [CNT_W-1:0]                    elem_cnt_next;
  logic                                en;
  logic                                accept;
  emht_pkg::item_ctl_t                 in_ctl;
  logic signed [emht_pkg::ELEM_W-1:0]  in_elem;
  logic                                counted;
  logic [ADDR_W-1:0]                   addr;
  logic                                mem_we;

  logic                                s1_valid;
  emht_pkg::item_ctl_t                 s1_ctl;
  logic                                s1_counted;
  logic signed [emht_pkg::ELEM_W-1:0]  s1_elem;
  logic signed [emht_pkg::ELEM_W-1:0]  ref_elem;

  logic                                s3_valid;
  emht_pkg::item_ctl_t                 s3_ctl;
  logic signed [ACC_W-1:0]             s3_sum;

  logic                                res_accepted;
  logic signed [emht_pkg::SCORE_W-1:0] res_score;
  logic                                res_visible;
  logic                                res_kind;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    in_ctl.cmd     = emht_pkg::cmd_t'(s_tuser);
    in_ctl.slot    = s_tdata[3:0];
    in_ctl.slot_ok = 32'(s_tdata[3:0]) < TRACK_SLOTS;
    in_ctl.match   = s_tdata[35:4] == current_generation;
    in_ctl.last    = s_tlast;
    in_ctl.thr     = s_tdata[68:52];
    in_ctl.known   = s_tdata[69];
    in_elem        = s_tdata[51:36];
    counted        = 32'(elem_cnt) < EMBED_LEN;
    addr           = {(in_ctl.slot_ok ? SLOT_W'(in_ctl.slot) : SLOT_W'(0)),
                      elem_cnt[IDX_W-1:0]};
    mem_we         = accept && counted && in_ctl.slot_ok && in_ctl.match &&
                     (in_ctl.cmd == emht_pkg::CMD_LOAD);
    if (s_tlast || in_ctl.cmd == emht_pkg::CMD_EXPIRE ||
        in_ctl.cmd == emht_pkg::CMD_CLEAR) begin
      elem_cnt_next = '0;
    end else if (counted) begin
      elem_cnt_next = elem_cnt + 1'b1;
    end else begin
      elem_cnt_next = elem_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_generation <= '0;
      elem_cnt           <= '0;
      s1_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        current_generation <= cfg_wdata;
      end
      if (en) begin
        s1_valid <= accept;
      end
      if (accept) begin
        elem_cnt <= elem_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl     <= in_ctl;
      s1_counted <= counted;
      s1_elem    <= in_elem;
    end
  end

  emht_ref_mem #(
    .TRACK_SLOTS (TRACK_SLOTS),
    .EMBED_LEN   (EMBED_LEN)
  ) u_ref_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (accept),
    .addr  (addr),
    .wdata (in_elem),
    .rdata (ref_elem)
  );

  emht_mac #(
    .EMBED_LEN (EMBED_LEN)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s1_valid),
    .in_ctl     (s1_ctl),
    .in_counted (s1_counted),
    .in_elem    (s1_elem),
    .ref_elem   (ref_elem),
    .out_valid  (s3_valid),
    .out_ctl    (s3_ctl),
    .out_sum    (s3_sum)
  );

  emht_slot_table #(
    .TRACK_SLOTS (TRACK_SLOTS),
    .RUN_LENGTH  (RUN_LENGTH),
    .ACC_W       (ACC_W)
  ) u_slot_table (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s3_valid),
    .in_ctl       (s3_ctl),
    .in_sum       (s3_sum),
    .res_valid    (m_tvalid),
    .res_accepted (res_accepted),
    .res_score    (res_score),
    .res_visible  (res_visible),
    .res_kind     (res_kind)
  );

  assign m_tdata = {5'b0, res_visible, res_score, res_accepted};
  assign m_tuser = res_kind;

  a_res_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s3_valid))
    else $error("result without a finished item");

  a_assign_score: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == emht_pkg::KIND_ASSIGN) |-> (m_tdata[17:1] == '0))
    else $error("assignment result with nonzero score");

  a_reject_score: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[17:1] == '0))
    else $error("rejected result with nonzero score");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> (32'(elem_cnt) <= EMBED_LEN))
    else $error("element counter out of range");

endmodule
